>>> sv/stsc_pkg.sv
// Shared types and constants for the submatrix target-sum counter.
// No dependencies; other sv/ files but stsc_prefix_mem use it by scoped names.
`default_nettype none

package stsc_pkg;

  // default sizing of the top level
  localparam int DEF_MAX_ROWS      = 64;
  localparam int DEF_MAX_COLUMNS   = 64;
  localparam int DEF_ELEMENT_WIDTH = 16;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SUM   = 2'd2;

  localparam int SIZE_CFG_W = 7;
  localparam logic [SIZE_CFG_W-1:0] SIZE_RESET = 7'd64;
  localparam int TARGET_W = 32;

  // result width; the count wraps at this width
  localparam int COUNT_W = 23;

  // one row step issued by the sweep sequencer
  typedef struct packed {
    logic valid;      // a row step is in this stage
    logic first;      // first row of a column pair
    logic left_zero;  // left column is column 0: no left prefix to subtract
    logic last;       // last row of the last column pair
  } stsc_issue_t;

endpackage

`default_nettype wire

>>> sv/stsc_prefix_mem.sv
// Row prefix-sum memory: one write port for loading, two registered read ports for the sweep.
// Depends on nothing but its parameters.
`default_nettype none

module stsc_prefix_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 22
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire        [ADDR_W-1:0]  wr_addr,
  input  wire signed [DATA_W-1:0]  wr_data,
  input  wire        [ADDR_W-1:0]  rd_addr_a,
  input  wire        [ADDR_W-1:0]  rd_addr_b,
  output logic signed [DATA_W-1:0] rd_data_a,
  output logic signed [DATA_W-1:0] rd_data_b
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

>>> sv/stsc_sweep_seq.sv
// Sweep sequencer: walks column pairs and rows, issues memory reads and row-step flags.
// Depends on stsc_pkg (stsc_issue_t).
`default_nettype none

module stsc_sweep_seq #(
  parameter int MAX_COLUMNS = 64,
  parameter int ADDR_W      = 12,
  parameter int IDX_R_W     = 6,
  parameter int IDX_C_W     = 6,
  parameter int CNT_R_W     = 7,
  parameter int CNT_C_W     = 7
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        go,
  input  wire        [CNT_R_W-1:0]   rows,
  input  wire        [CNT_C_W-1:0]   cols,
  input  wire                        done,
  output logic                       busy,
  output logic       [ADDR_W-1:0]    rd_addr_right,
  output logic       [ADDR_W-1:0]    rd_addr_left,
  output stsc_pkg::stsc_issue_t      issue
);

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [IDX_C_W-1:0] left_r, left_nxt;
  logic [IDX_C_W-1:0] right_r, right_nxt;
  logic [IDX_R_W-1:0] row_r, row_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;

  logic row_end, right_end, left_end;

  assign row_end   = (CNT_R_W'(row_r) == rows - CNT_R_W'(1));
  assign right_end = (CNT_C_W'(right_r) == cols - CNT_C_W'(1));
  assign left_end  = (CNT_C_W'(left_r) == cols - CNT_C_W'(1));

  assign busy = (state_r != S_LOAD);

  assign rd_addr_right = base_r + ADDR_W'(right_r);
  assign rd_addr_left  = (left_r == '0) ? rd_addr_right
                                        : base_r + ADDR_W'(left_r) - ADDR_W'(1);

  always_comb begin
    issue.valid     = (state_r == S_SWEEP);
    issue.first     = (row_r == '0);
    issue.left_zero = (left_r == '0);
    issue.last      = row_end && right_end && left_end;
  end

  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    row_nxt   = row_r;
    base_nxt  = base_r;
    case (state_r)
      S_LOAD: begin
        if (go) begin
          state_nxt = S_SWEEP;
          left_nxt  = '0;
          right_nxt = '0;
          row_nxt   = '0;
          base_nxt  = '0;
        end
      end
      S_SWEEP: begin
        if (row_end) begin
          row_nxt  = '0;
          base_nxt = '0;
          if (right_end) begin
            left_nxt  = left_r + IDX_C_W'(1);
            right_nxt = left_r + IDX_C_W'(1);
            if (left_end) begin
              state_nxt = S_DRAIN;
            end
          end else begin
            right_nxt = right_r + IDX_C_W'(1);
          end
        end else begin
          row_nxt  = row_r + IDX_R_W'(1);
          base_nxt = base_r + ADDR_W'(MAX_COLUMNS);
        end
      end
      S_DRAIN: begin
        if (done) begin
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      left_r  <= '0;
      right_r <= '0;
      row_r   <= '0;
      base_r  <= '0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      row_r   <= row_nxt;
      base_r  <= base_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/stsc_match_unit.sv
// Row-step datapath: span, running sum, seen-sum store with parallel match, count.
// Depends on stsc_pkg (stsc_issue_t, COUNT_W, TARGET_W); fed by stsc_prefix_mem reads.
`default_nettype none

module stsc_match_unit #(
  parameter int MAX_ROWS = 64,
  parameter int PREFIX_W = 22,
  parameter int RUN_W    = 28,
  parameter int BIAS_W   = 33
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     clear,
  input  wire stsc_pkg::stsc_issue_t              issue,
  input  wire signed [PREFIX_W-1:0]               rd_right,
  input  wire signed [PREFIX_W-1:0]               rd_left,
  input  wire signed [stsc_pkg::TARGET_W-1:0]     target,
  output logic                                    out_valid,
  output logic       [stsc_pkg::COUNT_W-1:0]      out_count
);

  localparam int SEEN_D = MAX_ROWS + 1;
  localparam int FILL_W = $clog2(SEEN_D + 1);
  localparam int POP_W  = $clog2(SEEN_D + 1);

  stsc_pkg::stsc_issue_t flags_b_r, flags_c_r, flags_d_r, flags_e_r, flags_f_r;

  logic signed [PREFIX_W-1:0] span_r;
  logic signed [RUN_W-1:0]    running_r;
  logic signed [BIAS_W-1:0]   biased_r;   // running sum plus target, as stored
  logic signed [BIAS_W-1:0]   seen_r [SEEN_D];
  logic        [FILL_W-1:0]   fill_r;
  logic        [SEEN_D-1:0]   match_r, match_nxt;
  logic        [POP_W-1:0]    pop_r;
  logic [stsc_pkg::COUNT_W-1:0] total_r, total_nxt;

  logic signed [BIAS_W-1:0] run_ext, tgt_ext;

  assign run_ext = BIAS_W'(running_r);
  assign tgt_ext = BIAS_W'(target);

  // flag pipeline: b aligns with registered memory data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_b_r <= '0;
      flags_c_r <= '0;
      flags_d_r <= '0;
      flags_e_r <= '0;
      flags_f_r <= '0;
    end else begin
      flags_b_r <= issue;
      flags_c_r <= flags_b_r;
      flags_d_r <= flags_c_r;
      flags_e_r <= flags_d_r;
      flags_f_r <= flags_e_r;
    end
  end

  // stage b: span of this row between the two columns
  always_ff @(posedge clk) begin
    if (flags_b_r.left_zero) begin
      span_r <= rd_right;
    end else begin
      span_r <= rd_right - rd_left;
    end
  end

  // stage c: running sum, kept both plain and offset by the target
  always_ff @(posedge clk) begin
    if (flags_c_r.valid) begin
      if (flags_c_r.first) begin
        running_r <= RUN_W'(span_r);
        biased_r  <= tgt_ext + BIAS_W'(span_r);
      end else begin
        running_r <= running_r + RUN_W'(span_r);
        biased_r  <= biased_r + BIAS_W'(span_r);
      end
    end
  end

  // stage d: seen(k) + target == running  <=>  seen(k) == running - target
  always_comb begin
    match_nxt = '0;
    if (flags_d_r.first) begin
      match_nxt[0] = (run_ext == tgt_ext);
    end else begin
      for (int k = 0; k < SEEN_D; k++) begin
        match_nxt[k] = (FILL_W'(k) < fill_r) && (seen_r[k] == run_ext);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flags_d_r.valid) begin
      match_r <= match_nxt;
      if (flags_d_r.first) begin
        seen_r[0] <= tgt_ext;
        seen_r[1] <= biased_r;
      end else begin
        for (int k = 0; k < SEEN_D; k++) begin
          if (FILL_W'(k) == fill_r) begin
            seen_r[k] <= biased_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (flags_d_r.valid) begin
      if (flags_d_r.first) begin
        fill_r <= FILL_W'(2);
      end else if (fill_r < FILL_W'(SEEN_D)) begin
        fill_r <= fill_r + FILL_W'(1);
      end
    end
  end

  // stage e: number of matches for this row
  always_ff @(posedge clk) begin
    pop_r <= POP_W'($countones(match_r));
  end

  // stage f: total, wraps at the result width
  assign total_nxt = total_r + stsc_pkg::COUNT_W'(pop_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= flags_f_r.valid && flags_f_r.last;
      if (clear) begin
        total_r <= '0;
      end else if (flags_f_r.valid) begin
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flags_f_r.valid && flags_f_r.last) begin
      out_count <= total_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/submatrix_target_sum_counter_top.sv
// Top level of the submatrix target-sum counter: configuration, matrix load, sweep.
// Depends on stsc_pkg, stsc_prefix_mem, stsc_sweep_seq and stsc_match_unit.
//
//   channel  | ports                                   | transfer
//   ---------+-----------------------------------------+------------------------------
//   input    | start, busy, in_element_value           | word taken when start && !busy
//   result   | out_valid, out_submatrix_count          | one-cycle strobe, no stall
//   config   | cfg_we, cfg_index, cfg_data             | write when cfg_we, no wait
//
// A matrix of R rows and C columns is R*C element words.
// After the last word busy stays high for R*C*(C+1)/2 row steps, one row step per
// cycle through the single span/accumulate/match pipeline, and until the count strobes.
// No clearing pass after reset; the block takes words from the first cycle.
// The receiver cannot stall: out_valid is high for exactly one cycle per matrix.
`default_nettype none

module submatrix_target_sum_counter_top #(
  parameter int MAX_ROWS      = stsc_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLUMNS   = stsc_pkg::DEF_MAX_COLUMNS,
  parameter int ELEMENT_WIDTH = stsc_pkg::DEF_ELEMENT_WIDTH
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  output logic                                  busy,
  input  wire signed [ELEMENT_WIDTH-1:0]        in_element_value,
  output logic                                  out_valid,
  output logic       [stsc_pkg::COUNT_W-1:0]    out_submatrix_count,
  input  wire                                   cfg_we,
  input  wire        [stsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire        [stsc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int PREFIX_W = ELEMENT_WIDTH + $clog2(MAX_COLUMNS);
  localparam int RUN_W    = PREFIX_W + $clog2(MAX_ROWS);
  localparam int BIAS_W   = ((RUN_W > stsc_pkg::TARGET_W) ? RUN_W : stsc_pkg::TARGET_W) + 1;
  localparam int DEPTH    = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_R_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int IDX_C_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_R_W  = $clog2(MAX_ROWS + 1);
  localparam int CNT_C_W  = $clog2(MAX_COLUMNS + 1);

  logic [stsc_pkg::SIZE_CFG_W-1:0]      row_cfg_r, col_cfg_r;
  logic signed [stsc_pkg::TARGET_W-1:0] target_r;
  logic                                 size_write;

  logic [CNT_R_W-1:0] rows_used;
  logic [CNT_C_W-1:0] cols_used;

  logic                       accept, last_word;
  logic [IDX_R_W-1:0]         load_row_r;
  logic [IDX_C_W-1:0]         load_col_r;
  logic [ADDR_W-1:0]          load_base_r;
  logic signed [PREFIX_W-1:0] prefix_r, prefix_nxt;
  logic [ADDR_W-1:0]          wr_addr;

  logic [ADDR_W-1:0]          rd_addr_right, rd_addr_left;
  logic signed [PREFIX_W-1:0] rd_right, rd_left;
  stsc_pkg::stsc_issue_t      issue;

  // configuration registers
  assign size_write = cfg_we && ((cfg_index == stsc_pkg::CFG_ROW_COUNT) ||
                                 (cfg_index == stsc_pkg::CFG_COLUMN_COUNT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cfg_r <= stsc_pkg::SIZE_RESET;
      col_cfg_r <= stsc_pkg::SIZE_RESET;
      target_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        stsc_pkg::CFG_ROW_COUNT:    row_cfg_r <= cfg_data[stsc_pkg::SIZE_CFG_W-1:0];
        stsc_pkg::CFG_COLUMN_COUNT: col_cfg_r <= cfg_data[stsc_pkg::SIZE_CFG_W-1:0];
        stsc_pkg::CFG_TARGET_SUM:   target_r  <= cfg_data[stsc_pkg::TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  // zero counts as one, anything above the maximum as the maximum
  always_comb begin
    if (row_cfg_r == '0) begin
      rows_used = CNT_R_W'(1);
    end else if (row_cfg_r > MAX_ROWS) begin
      rows_used = CNT_R_W'(MAX_ROWS);
    end else begin
      rows_used = CNT_R_W'(row_cfg_r);
    end
    if (col_cfg_r == '0) begin
      cols_used = CNT_C_W'(1);
    end else if (col_cfg_r > MAX_COLUMNS) begin
      cols_used = CNT_C_W'(MAX_COLUMNS);
    end else begin
      cols_used = CNT_C_W'(col_cfg_r);
    end
  end

  // matrix load: prefix along the row comes from the previous word
  assign accept     = start && !busy;
  assign last_word  = (CNT_R_W'(load_row_r) == rows_used - CNT_R_W'(1)) &&
                      (CNT_C_W'(load_col_r) == cols_used - CNT_C_W'(1));
  assign wr_addr    = load_base_r + ADDR_W'(load_col_r);
  assign prefix_nxt = (load_col_r == '0) ? PREFIX_W'(in_element_value)
                                         : prefix_r + PREFIX_W'(in_element_value);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_row_r  <= '0;
      load_col_r  <= '0;
      load_base_r <= '0;
    end else if (size_write) begin
      load_row_r  <= '0;
      load_col_r  <= '0;
      load_base_r <= '0;
    end else if (accept) begin
      if (last_word) begin
        load_row_r  <= '0;
        load_col_r  <= '0;
        load_base_r <= '0;
      end else if (CNT_C_W'(load_col_r) == cols_used - CNT_C_W'(1)) begin
        load_col_r  <= '0;
        load_row_r  <= load_row_r + IDX_R_W'(1);
        load_base_r <= load_base_r + ADDR_W'(MAX_COLUMNS);
      end else begin
        load_col_r  <= load_col_r + IDX_C_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prefix_r <= prefix_nxt;
    end
  end

  stsc_prefix_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (PREFIX_W)
  ) u_mem (
    .clk       (clk),
    .wr_en     (accept),
    .wr_addr   (wr_addr),
    .wr_data   (prefix_nxt),
    .rd_addr_a (rd_addr_right),
    .rd_addr_b (rd_addr_left),
    .rd_data_a (rd_right),
    .rd_data_b (rd_left)
  );

  stsc_sweep_seq #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .ADDR_W      (ADDR_W),
    .IDX_R_W     (IDX_R_W),
    .IDX_C_W     (IDX_C_W),
    .CNT_R_W     (CNT_R_W),
    .CNT_C_W     (CNT_C_W)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (accept && last_word),
    .rows          (rows_used),
    .cols          (cols_used),
    .done          (out_valid),
    .busy          (busy),
    .rd_addr_right (rd_addr_right),
    .rd_addr_left  (rd_addr_left),
    .issue         (issue)
  );

  stsc_match_unit #(
    .MAX_ROWS (MAX_ROWS),
    .PREFIX_W (PREFIX_W),
    .RUN_W    (RUN_W),
    .BIAS_W   (BIAS_W)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (accept && last_word),
    .issue     (issue),
    .rd_right  (rd_right),
    .rd_left   (rd_left),
    .target    (target_r),
    .out_valid (out_valid),
    .out_count (out_submatrix_count)
  );

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking bench for submatrix_target_sum_counter_top: streams matrices, predicts counts.
// Depends on stsc_pkg and the RTL under sv/; a local predictor checks every count word.
`timescale 1ns / 1ps

module tb_top;

  localparam int ROWS_MAX     = stsc_pkg::DEF_MAX_ROWS;
  localparam int COLS_MAX     = stsc_pkg::DEF_MAX_COLUMNS;
  localparam int ELEM_W       = stsc_pkg::DEF_ELEMENT_WIDTH;
  localparam int RANDOM_WORDS = 2000;
  localparam int SETTLE       = 8;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam logic [stsc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct {
    logic signed [ELEM_W-1:0] value;
    int unsigned              gap;
  } elem_word_t;

  logic                                   clk = 1'b0;
  logic                                   rst_n = 1'b0;
  logic                                   start = 1'b0;
  logic                                   busy;
  logic signed [ELEM_W-1:0]               in_element_value = '0;
  logic                                   out_valid;
  logic        [stsc_pkg::COUNT_W-1:0]    out_submatrix_count;
  logic                                   cfg_we = 1'b0;
  logic        [stsc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic        [stsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  submatrix_target_sum_counter_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_element_value    (in_element_value),
    .out_valid           (out_valid),
    .out_submatrix_count (out_submatrix_count),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // predictor state
  logic        [stsc_pkg::SIZE_CFG_W-1:0] rows_cfg = stsc_pkg::SIZE_RESET;
  logic        [stsc_pkg::SIZE_CFG_W-1:0] cols_cfg = stsc_pkg::SIZE_RESET;
  logic signed [stsc_pkg::TARGET_W-1:0]   target_cfg = '0;
  logic signed [21:0]                     row_prefix_sums [ROWS_MAX*COLS_MAX];
  int                                     load_pos = 0;

  elem_word_t                   pending_words[$];
  logic [stsc_pkg::COUNT_W-1:0] expected_counts[$];
  elem_word_t                   nxt_word;
  int                           words_in_flight = 0;
  int                           gap_cnt = 0;
  int unsigned                  gap_max = 0;

  int unsigned cycle_cnt = 0;
  int          err_cnt = 0;
  int          words_taken = 0;
  int          counts_checked = 0;
  int          reg_writes = 0;
  int          random_words = 0;
  int          big_phases = 0;

  initial forever #5 clk = ~clk;

  function automatic int used_dim(logic [stsc_pkg::SIZE_CFG_W-1:0] v, int max_dim);
    if (v == 0) return 1;
    if (v > max_dim) return max_dim;
    return int'(v);
  endfunction

  // every column pair, rows walked top to bottom, all earlier running sums checked in turn
  function automatic logic [stsc_pkg::COUNT_W-1:0] count_target_spans(int nr, int nc);
    logic signed [27:0] seen [ROWS_MAX+1];
    logic signed [21:0] span;
    logic signed [27:0] acc;
    longint             want;
    longint             total;
    int                 fill;
    int                 lft;
    int                 rgt;
    int                 y;
    int                 k;
    total = 0;
    for (lft = 0; lft < nc; lft++) begin
      for (rgt = lft; rgt < nc; rgt++) begin
        seen[0] = '0;
        fill = 1;
        acc = '0;
        for (y = 0; y < nr; y++) begin
          span = row_prefix_sums[y*COLS_MAX + rgt];
          if (lft > 0) span = span - row_prefix_sums[y*COLS_MAX + lft - 1];
          acc = acc + span;
          want = longint'(acc) - longint'(target_cfg);
          for (k = 0; k < fill; k++)
            if (longint'(seen[k]) == want) total++;
          if (fill < ROWS_MAX + 1) begin
            seen[fill] = acc;
            fill++;
          end
        end
      end
    end
    return total[stsc_pkg::COUNT_W-1:0];
  endfunction

  function automatic void load_element(logic signed [ELEM_W-1:0] v);
    int nr;
    int nc;
    int c;
    int slot;
    nr = used_dim(rows_cfg, ROWS_MAX);
    nc = used_dim(cols_cfg, COLS_MAX);
    if (load_pos >= nr*nc) load_pos = 0;
    c = load_pos % nc;
    slot = (load_pos / nc) * COLS_MAX + c;
    if (c == 0) row_prefix_sums[slot] = v;
    else row_prefix_sums[slot] = row_prefix_sums[slot-1] + v;
    if (load_pos + 1 >= nr*nc) begin
      load_pos = 0;
      expected_counts.push_back(count_target_spans(nr, nc));
    end else begin
      load_pos++;
    end
  endfunction

  function automatic void apply_reg(logic [stsc_pkg::CFG_IDX_W-1:0] idx,
                                    logic [stsc_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      stsc_pkg::CFG_ROW_COUNT: begin
        rows_cfg = d[stsc_pkg::SIZE_CFG_W-1:0];
        load_pos = 0;
      end
      stsc_pkg::CFG_COLUMN_COUNT: begin
        cols_cfg = d[stsc_pkg::SIZE_CFG_W-1:0];
        load_pos = 0;
      end
      stsc_pkg::CFG_TARGET_SUM: target_cfg = d[stsc_pkg::TARGET_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void report_mismatch(string what,
                                          logic [stsc_pkg::COUNT_W-1:0] exp_cnt,
                                          logic [stsc_pkg::COUNT_W-1:0] act_cnt);
    err_cnt++;
    if (err_cnt <= 10)
      $display("[%0t] %s: submatrix_count expected %0d got %0d", $realtime, what,
               exp_cnt, act_cnt);
  endfunction

  function automatic void add_word(logic [ELEM_W-1:0] v);
    elem_word_t w;
    w.value = v;
    w.gap = $urandom_range(0, gap_max);
    pending_words.push_back(w);
    words_in_flight++;
  endfunction

  function automatic logic [ELEM_W-1:0] draw_element(int mode);
    case (mode)
      0: return ELEM_W'(int'($urandom_range(0, 4)) - 2);
      1: return ELEM_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: return {1'b1, {(ELEM_W-1){1'b0}}};
          1: return {1'b0, {(ELEM_W-1){1'b1}}};
          2: return '0;
          default: return ELEM_W'(int'($urandom_range(0, 2)) - 1);
        endcase
      end
    endcase
  endfunction

  // size registers get random bits above the 7 that count
  task automatic write_reg(logic [stsc_pkg::CFG_IDX_W-1:0] idx,
                           logic [stsc_pkg::CFG_DATA_W-1:0] d);
    logic [stsc_pkg::CFG_DATA_W-1:0] w;
    w = d;
    if (idx == stsc_pkg::CFG_ROW_COUNT || idx == stsc_pkg::CFG_COLUMN_COUNT)
      w = ($urandom & ~stsc_pkg::CFG_DATA_W'(7'h7F)) | (d & stsc_pkg::CFG_DATA_W'(7'h7F));
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= w;
    apply_reg(idx, w);
    reg_writes++;
  endtask

  task automatic cfg_done();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (words_in_flight != 0 || expected_counts.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_matrices(int n_mats, int mode);
    int i;
    int total;
    total = used_dim(rows_cfg, ROWS_MAX) * used_dim(cols_cfg, COLS_MAX) * n_mats;
    for (i = 0; i < total; i++) begin
      add_word(draw_element(mode));
      random_words++;
    end
  endtask

  // driver: start stays up across back-to-back words
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_cnt <= 0;
    end else if (start && !busy) begin
      load_element(in_element_value);
      words_in_flight--;
      words_taken++;
      if (pending_words.size() != 0 && pending_words[0].gap == 0) begin
        nxt_word = pending_words.pop_front();
        in_element_value <= nxt_word.value;
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_words.size() != 0) begin
      if (gap_cnt < pending_words[0].gap) begin
        gap_cnt <= gap_cnt + 1;
      end else begin
        nxt_word = pending_words.pop_front();
        in_element_value <= nxt_word.value;
        start <= 1'b1;
        gap_cnt <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_counts.size() == 0) begin
        report_mismatch("unexpected word", '0, out_submatrix_count);
      end else begin
        if (out_submatrix_count !== expected_counts[0])
          report_mismatch("mismatch", expected_counts[0], out_submatrix_count);
        void'(expected_counts.pop_front());
        counts_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    int i;
    int mode;
    int nr;
    int nc;
    int part;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset sizes: full 64x64 all-zero matrix gives the largest possible count
    gap_max = 18;
    for (i = 0; i < ROWS_MAX*COLS_MAX; i++) add_word('0);
    wait_idle();

    // 1x1 through zero sizes, element extremes against matching targets
    gap_max = 0;
    write_reg(stsc_pkg::CFG_ROW_COUNT, 0);
    write_reg(stsc_pkg::CFG_COLUMN_COUNT, 0);
    write_reg(stsc_pkg::CFG_TARGET_SUM, 0);
    cfg_done();
    add_word(16'h0000);
    add_word(16'h0005);
    wait_idle();
    write_reg(stsc_pkg::CFG_TARGET_SUM, 32'hFFFF_8000);
    cfg_done();
    add_word(16'h8000);
    wait_idle();
    write_reg(stsc_pkg::CFG_TARGET_SUM, 32'h0000_7FFF);
    cfg_done();
    add_word(16'h7FFF);
    wait_idle();

    // 2x2 against the target extremes
    gap_max = 18;
    write_reg(stsc_pkg::CFG_ROW_COUNT, 2);
    write_reg(stsc_pkg::CFG_COLUMN_COUNT, 2);
    write_reg(stsc_pkg::CFG_TARGET_SUM, 32'h8000_0000);
    cfg_done();
    add_word(16'h7FFF);
    add_word(16'h8000);
    add_word(16'h0001);
    add_word(16'hFFFF);
    wait_idle();
    write_reg(stsc_pkg::CFG_TARGET_SUM, 32'h7FFF_FFFF);
    cfg_done();
    repeat (4) add_word(16'h7FFF);
    wait_idle();

    // partial load survives target and unused-index writes, dies on a size write
    write_reg(stsc_pkg::CFG_ROW_COUNT, 2);
    write_reg(stsc_pkg::CFG_COLUMN_COUNT, 3);
    write_reg(stsc_pkg::CFG_TARGET_SUM, 0);
    cfg_done();
    add_word(16'h0001);
    add_word(16'hFFFF);
    add_word(16'h0000);
    add_word(16'h0002);
    wait_idle();
    write_reg(CFG_UNUSED_IDX, $urandom);
    write_reg(stsc_pkg::CFG_TARGET_SUM, 1);
    cfg_done();
    add_word(16'hFFFE);
    add_word(16'h0001);
    wait_idle();
    add_word(16'h0003);
    add_word(16'h0001);
    add_word(16'hFFFF);
    wait_idle();
    write_reg(stsc_pkg::CFG_COLUMN_COUNT, 3);
    cfg_done();
    for (i = 0; i < 6; i++) add_word(16'(int'($urandom_range(0, 2)) - 1));
    wait_idle();

    // random phases
    while (random_words < RANDOM_WORDS) begin
      mode = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 2);
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
      if ($urandom_range(0, 7) != 0) begin
        nr = $urandom_range(1, 8);
        nc = $urandom_range(1, 8);
        case ($urandom_range(0, 11))
          0: nr = 0;
          1: nc = 0;
          2: if (big_phases < 6) begin
            big_phases++;
            if ($urandom_range(0, 1) == 0) begin
              nr = ($urandom_range(0, 1) == 0) ? 64 : $urandom_range(65, 127);
              nc = $urandom_range(1, 3);
            end else begin
              nc = ($urandom_range(0, 1) == 0) ? 64 : $urandom_range(65, 127);
              nr = $urandom_range(1, 3);
            end
          end
          default: ;
        endcase
        write_reg(stsc_pkg::CFG_ROW_COUNT, nr);
        write_reg(stsc_pkg::CFG_COLUMN_COUNT, nc);
      end
      if (mode == 0)
        write_reg(stsc_pkg::CFG_TARGET_SUM, 32'(int'($urandom_range(0, 6)) - 3));
      else
        case ($urandom_range(0, 4))
          0: write_reg(stsc_pkg::CFG_TARGET_SUM, $urandom);
          1: write_reg(stsc_pkg::CFG_TARGET_SUM, 32'h8000_0000);
          2: write_reg(stsc_pkg::CFG_TARGET_SUM, 32'h7FFF_FFFF);
          3: write_reg(stsc_pkg::CFG_TARGET_SUM,
                       32'(int'($urandom_range(0, 4)) - 2) << 15);
          default: write_reg(stsc_pkg::CFG_TARGET_SUM, 0);
        endcase
      cfg_done();
      send_matrices($urandom_range(1, 3), mode);
      // now and then leave a matrix partly loaded for the next phase
      nr = used_dim(rows_cfg, ROWS_MAX) * used_dim(cols_cfg, COLS_MAX);
      if (nr > 1 && $urandom_range(0, 4) == 0) begin
        part = $urandom_range(1, nr - 1);
        for (i = 0; i < part; i++) add_word(draw_element(mode));
      end
      wait_idle();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    while (expected_counts.size() != 0)
      report_mismatch("missing word", expected_counts.pop_front(), '0);

    $display("checked %0d submatrix counts from %0d element words", counts_checked,
             words_taken);
    $display("%0d register writes, %0d large-size phases, %0d errors", reg_writes,
             big_phases, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/stsc_pkg.sv
sv/stsc_prefix_mem.sv
sv/stsc_sweep_seq.sv
sv/stsc_match_unit.sv
sv/submatrix_target_sum_counter_top.sv
verif/tb_top.sv
